>>> hdl/ltd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ77 triple decoder package
// Shared widths, queue depths and the command type passed from front to back.
// ----------------------------------------------------------------------------
package ltd_pkg;

  localparam int unsigned WINDOW_DEPTH = 4096;
  localparam int unsigned WINDOW_AW    = $clog2(WINDOW_DEPTH);
  localparam int unsigned MAX_COPY     = 63;

  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BYTE_W   = 8;

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);

  typedef logic [WINDOW_AW-1:0] addr_t;
  typedef logic [BYTE_W-1:0]    byte_t;

  typedef struct packed {
    addr_t            distance;
    logic [LEN_W-1:0] count;
    byte_t            literal;
  } cmd_t;

endpackage
`default_nettype wire

>>> hdl/ltd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ltd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/ltd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ77 triple decoder front end
// Accepts triples, turns them into copy commands and holds them in a short
// queue for the back end.
// ----------------------------------------------------------------------------
module ltd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [ltd_pkg::OFFSET_W-1:0]  match_offset_i,
  input  wire logic [ltd_pkg::LEN_W-1:0]     match_length_i,
  input  wire logic [ltd_pkg::BYTE_W-1:0]    literal_byte_i,
  output logic                               cmd_valid_o,
  output ltd_pkg::cmd_t                      cmd_o,
  input  wire logic                          cmd_pop_i
);
  import ltd_pkg::*;

  cmd_t               slot_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_AW:0]   cnt_q, cnt_d;
  cmd_t               new_cmd;
  logic               do_push;
  logic               do_pop;

  assign full        = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    new_cmd.distance = addr_t'(match_offset_i);
    new_cmd.literal  = literal_byte_i;
    if (match_offset_i == '0) begin
      new_cmd.count = '0;
    end else if (match_length_i > LEN_W'(MAX_COPY)) begin
      new_cmd.count = LEN_W'(MAX_COPY);
    end else begin
      new_cmd.count = match_length_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ltd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ77 triple decoder back end
// Runs one command at a time: reads copied bytes from the history window,
// appends every emitted byte to it and queues the bytes for the output.
// ----------------------------------------------------------------------------
module ltd_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  input  ltd_pkg::cmd_t                    cmd_i,
  output logic                             cmd_pop_o,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [ltd_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             last_of_item_o
);
  import ltd_pkg::*;

  // Command currently being carried out.
  logic             busy_q, busy_d;
  addr_t            dist_q;
  logic [LEN_W-1:0] rem_q, rem_d;
  byte_t            lit_q;

  // Issue pointer and fill tracking of the window.
  addr_t iwp_q, iwp_d;
  logic  wrapped_q, wrapped_d;

  // Second stage: the byte whose read was issued in the previous cycle.
  logic  s2_valid_q, s2_valid_d;
  logic  s2_is_lit_q;
  logic  s2_bypass_q;
  logic  s2_zero_q;
  addr_t s2_addr_q;
  byte_t s2_lit_q;
  byte_t s2_byte;
  byte_t last_byte_q;
  byte_t ram_rdata;

  // Output queue.
  byte_t              oq_byte_q [OUTQ_DEPTH];
  logic               oq_last_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wr_q, oq_wr_d;
  logic [OUTQ_AW-1:0] oq_rd_q, oq_rd_d;
  logic [OUTQ_AW:0]   oq_cnt_q, oq_cnt_d;
  logic               oq_push;
  logic               oq_pop;

  logic  space;
  logic  issue;
  logic  issue_copy;
  addr_t rd_addr;

  assign cmd_pop_o  = !busy_q && cmd_valid_i;
  assign space      = ((oq_cnt_q + (OUTQ_AW+1)'(s2_valid_q)) < (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign issue      = busy_q && space;
  assign issue_copy = issue && (rem_q != '0);
  assign rd_addr    = iwp_q - dist_q;

  always_comb begin
    busy_d     = busy_q;
    rem_d      = rem_q;
    iwp_d      = iwp_q;
    wrapped_d  = wrapped_q;
    s2_valid_d = issue;
    if (cmd_pop_o) begin
      busy_d = 1'b1;
      rem_d  = cmd_i.count;
    end else if (issue) begin
      iwp_d = iwp_q + 1'b1;
      if (iwp_q == '1) begin
        wrapped_d = 1'b1;
      end
      if (rem_q != '0) begin
        rem_d = rem_q - 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rem_q      <= '0;
      iwp_q      <= '0;
      wrapped_q  <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      rem_q      <= rem_d;
      iwp_q      <= iwp_d;
      wrapped_q  <= wrapped_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      dist_q <= cmd_i.distance;
      lit_q  <= cmd_i.literal;
    end
    if (issue) begin
      s2_is_lit_q <= !issue_copy;
      s2_bypass_q <= s2_valid_q && (rd_addr == s2_addr_q);
      s2_zero_q   <= !wrapped_q && !(rd_addr < iwp_q);
      s2_addr_q   <= iwp_q;
      s2_lit_q    <= lit_q;
    end
    if (s2_valid_q) begin
      last_byte_q <= s2_byte;
    end
  end

  always_comb begin
    if (s2_is_lit_q) begin
      s2_byte = s2_lit_q;
    end else if (s2_bypass_q) begin
      s2_byte = last_byte_q;
    end else if (s2_zero_q) begin
      s2_byte = '0;
    end else begin
      s2_byte = ram_rdata;
    end
  end

  ltd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (s2_valid_q),
    .waddr_i (s2_addr_q),
    .wdata_i (s2_byte),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign oq_push        = s2_valid_q;
  assign empty          = (oq_cnt_q == '0);
  assign oq_pop         = pop && !empty;
  assign out_byte_o     = oq_byte_q[oq_rd_q];
  assign last_of_item_o = oq_last_q[oq_rd_q];

  always_comb begin
    oq_wr_d  = oq_wr_q;
    oq_rd_d  = oq_rd_q;
    oq_cnt_d = oq_cnt_q;
    if (oq_push) begin
      oq_wr_d = (oq_wr_q == OUTQ_AW'(OUTQ_DEPTH-1)) ? '0 : oq_wr_q + 1'b1;
    end
    if (oq_pop) begin
      oq_rd_d = (oq_rd_q == OUTQ_AW'(OUTQ_DEPTH-1)) ? '0 : oq_rd_q + 1'b1;
    end
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_wr_q  <= oq_wr_d;
      oq_rd_q  <= oq_rd_d;
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_byte_q[oq_wr_q] <= s2_byte;
      oq_last_q[oq_wr_q] <= s2_is_lit_q;
    end
  end

endmodule
`default_nettype wire

>>> hdl/lz77_triple_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LZ77 triple decoder core
// Decodes (offset, length, literal) triples into a byte stream.
// ----------------------------------------------------------------------------
// A triple with length n and a nonzero offset yields n copied bytes followed
// by its literal; a zero offset yields the literal alone. The last byte of
// each triple is marked. Within a triple, bytes come out at one per cycle
// while the output queue has room, limited by the single read port of the
// 4096-byte history RAM; each command is first loaded into the back end.
// A two-entry command queue lets new triples be taken while an earlier one
// is still being decoded. The window needs no clearing after reset: places
// not yet written read as zero.
// ----------------------------------------------------------------------------
module lz77_triple_decoder_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [ltd_pkg::OFFSET_W-1:0]  match_offset_i,
  input  wire logic [ltd_pkg::LEN_W-1:0]     match_length_i,
  input  wire logic [ltd_pkg::BYTE_W-1:0]    literal_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [ltd_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                               last_of_item_o
);
  import ltd_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  ltd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .match_offset_i (match_offset_i),
    .match_length_i (match_length_i),
    .literal_byte_i (literal_byte_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  ltd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
`default_nettype wire
